>>> hdl/hkts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Held-Karp tour solver package
// Shared widths, register map, item codes and the sequencer state type.
// ----------------------------------------------------------------------------
package hkts_pkg;

  // Word field widths, fixed by the item format
  localparam int CITY_W     = 4;
  localparam int WEIGHT_IN_W = 16;
  localparam int COST_OUT_W = 20;
  localparam int COUNT_W    = 4;

  // Build defaults
  localparam int DEF_MAX_CITIES  = 12;
  localparam int DEF_WEIGHT_BITS = 16;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CITY_COUNT = REG_IDX_W'(0);
  localparam logic [COUNT_W-1:0]   CITY_COUNT_RST = COUNT_W'(1);

  // Input word modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SOLVE = 1'b1;

  // Solver sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PICK,
    ST_SCAN,
    ST_FLUSH,
    ST_STORE,
    ST_TOUR_RD,
    ST_TOUR_CAP0,
    ST_TOUR_OUT,
    ST_TOUR_CAP
  } state_e;

endpackage
`default_nettype wire

>>> hdl/hkts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Held-Karp tour solver channels
// Valid/ready channels for input words (loads and solves) and tour words.
// ----------------------------------------------------------------------------
interface hkts_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [hkts_pkg::CITY_W-1:0]      from_city;
  logic [hkts_pkg::CITY_W-1:0]      to_city;
  logic [hkts_pkg::WEIGHT_IN_W-1:0] weight;

  modport source (output valid, mode, from_city, to_city, weight, input ready);
  modport sink   (input valid, mode, from_city, to_city, weight, output ready);
endinterface

interface hkts_out_if;
  logic                          valid;
  logic                          ready;
  logic [hkts_pkg::CITY_W-1:0]     city;
  logic [hkts_pkg::COST_OUT_W-1:0] tour_cost;
  logic                          last;

  modport source (output valid, city, tour_cost, last, input ready);
  modport sink   (input valid, city, tour_cost, last, output ready);
endinterface
`default_nettype wire

>>> hdl/hkts_dist_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance memory
// Square weight matrix, one write port and two registered read ports.
// Port B always reads column 0 (the edge back home).
// ----------------------------------------------------------------------------
module hkts_dist_mem #(
  parameter int MAX_CITIES  = hkts_pkg::DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = hkts_pkg::DEF_WEIGHT_BITS,
  localparam int CIW        = $clog2(MAX_CITIES),
  localparam int DEPTH      = MAX_CITIES * MAX_CITIES,
  localparam int AW         = $clog2(DEPTH)
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [CIW-1:0]         wrow_i,
  input  wire logic [CIW-1:0]         wcol_i,
  input  wire logic [WEIGHT_BITS-1:0] wdata_i,
  input  wire logic [CIW-1:0]         a_row_i,
  input  wire logic [CIW-1:0]         a_col_i,
  input  wire logic [CIW-1:0]         b_row_i,
  output logic      [WEIGHT_BITS-1:0] a_data_o,
  output logic      [WEIGHT_BITS-1:0] b_data_o
);

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] a_data_q;
  logic [WEIGHT_BITS-1:0] b_data_q;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          a_addr;
  logic [AW-1:0]          b_addr;

  // Flatten row and column into a linear address
  assign waddr  = AW'(int'(wrow_i) * MAX_CITIES + int'(wcol_i));
  assign a_addr = AW'(int'(a_row_i) * MAX_CITIES + int'(a_col_i));
  assign b_addr = AW'(int'(b_row_i) * MAX_CITIES);

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr] <= wdata_i;
    end
    a_data_q <= mem[a_addr];
    b_data_q <= mem[b_addr];
  end

  assign a_data_o = a_data_q;
  assign b_data_o = b_data_q;

endmodule
`default_nettype wire

>>> hdl/hkts_table_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subset table memory
// One entry per (visited set, current city): least remaining cost and best
// next city. City 0 is always visited, so mask bit 0 is left out of the
// address. One write port, one registered read port.
// ----------------------------------------------------------------------------
module hkts_table_mem #(
  parameter int MAX_CITIES  = hkts_pkg::DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = hkts_pkg::DEF_WEIGHT_BITS,
  localparam int CIW        = $clog2(MAX_CITIES),
  localparam int COST_W     = WEIGHT_BITS + $clog2(MAX_CITIES),
  localparam int MW         = MAX_CITIES - 1,
  localparam int AW         = MW + CIW,
  localparam int DW         = COST_W + CIW
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [MW-1:0]     wmask_i,
  input  wire logic [CIW-1:0]    wcity_i,
  input  wire logic [COST_W-1:0] wcost_i,
  input  wire logic [CIW-1:0]    wnext_i,
  input  wire logic [MW-1:0]     rmask_i,
  input  wire logic [CIW-1:0]    rcity_i,
  output logic      [COST_W-1:0] rcost_o,
  output logic      [CIW-1:0]    rnext_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[{wmask_i, wcity_i}] <= {wcost_i, wnext_i};
    end
    rdata_q <= mem[{rmask_i, rcity_i}];
  end

  assign rcost_o = rdata_q[DW-1:CIW];
  assign rnext_o = rdata_q[CIW-1:0];

endmodule
`default_nettype wire

>>> hdl/hkts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Solver sequencer
// Takes input words, fills the subset table bottom-up by read-compare-write
// over the memories, then walks the best-next chain and emits tour words.
// ----------------------------------------------------------------------------
module hkts_ctrl #(
  parameter int MAX_CITIES  = hkts_pkg::DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = hkts_pkg::DEF_WEIGHT_BITS,
  localparam int CIW        = $clog2(MAX_CITIES),
  localparam int CNT_W      = $clog2(MAX_CITIES + 1),
  localparam int COST_W     = WEIGHT_BITS + $clog2(MAX_CITIES),
  localparam int MW         = MAX_CITIES - 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [CNT_W-1:0]       n_i,
  hkts_in_if.sink                     in_if,
  hkts_out_if.source                  out_if,
  // distance memory
  output logic                        dist_we_o,
  output logic      [CIW-1:0]         dist_wrow_o,
  output logic      [CIW-1:0]         dist_wcol_o,
  output logic      [WEIGHT_BITS-1:0] dist_wdata_o,
  output logic      [CIW-1:0]         dist_a_row_o,
  output logic      [CIW-1:0]         dist_a_col_o,
  output logic      [CIW-1:0]         dist_b_row_o,
  input  wire logic [WEIGHT_BITS-1:0] dist_a_data_i,
  input  wire logic [WEIGHT_BITS-1:0] dist_b_data_i,
  // subset table
  output logic                        tbl_we_o,
  output logic      [MW-1:0]          tbl_wmask_o,
  output logic      [CIW-1:0]         tbl_wcity_o,
  output logic      [COST_W-1:0]      tbl_wcost_o,
  output logic      [CIW-1:0]         tbl_wnext_o,
  output logic      [MW-1:0]          tbl_rmask_o,
  output logic      [CIW-1:0]         tbl_rcity_o,
  input  wire logic [COST_W-1:0]      tbl_rcost_i,
  input  wire logic [CIW-1:0]         tbl_rnext_i
);

  hkts_pkg::state_e state_q, state_d;

  logic [MAX_CITIES-1:0] m_q, m_d;
  logic [CIW-1:0]        p_q, p_d;
  logic [CIW-1:0]        nx_q, nx_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COST_W-1:0]     cost_q, cost_d;

  // compare stage
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_full_q, s1_full_d;
  logic [CIW-1:0]        s1_nx_q, s1_nx_d;
  logic                  found_q, found_d;
  logic [COST_W-1:0]     best_q, best_d;
  logic [CIW-1:0]        best_city_q, best_city_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [CIW-1:0]        out_city_q, out_city_d;
  logic                  out_last_q, out_last_d;

  logic [MAX_CITIES-1:0] full_mask;
  logic [MAX_CITIES-1:0] next_mask;
  logic [COST_W-1:0]     cand;
  logic                  in_acc;
  logic                  in_range;
  logic                  p_last;
  logic                  nx_last;
  logic                  advance;

  // Mask of all active cities
  always_comb begin
    for (int i = 0; i < MAX_CITIES; i++) begin
      full_mask[i] = (i < int'(n_i));
    end
  end

  assign next_mask = m_q | (MAX_CITIES'(1) << nx_q);
  assign p_last    = (CNT_W'(p_q) == n_i - CNT_W'(1));
  assign nx_last   = (CNT_W'(nx_q) == n_i - CNT_W'(1));
  assign in_acc    = in_if.valid && in_if.ready;
  assign in_range  = (int'(in_if.from_city) < MAX_CITIES) &&
                     (int'(in_if.to_city) < MAX_CITIES);

  // Candidate cost: edge out plus what remains from the next city
  assign cand = COST_W'(dist_a_data_i) +
                (s1_full_q ? COST_W'(dist_b_data_i) : tbl_rcost_i);

  // Load path
  assign in_if.ready  = (state_q == hkts_pkg::ST_IDLE);
  assign dist_we_o    = in_acc && (in_if.mode == hkts_pkg::MODE_LOAD) && in_range;
  assign dist_wrow_o  = CIW'(in_if.from_city);
  assign dist_wcol_o  = CIW'(in_if.to_city);
  assign dist_wdata_o = WEIGHT_BITS'(in_if.weight);

  // Table write port follows the current entry
  assign tbl_wmask_o = m_q[MAX_CITIES-1:1];
  assign tbl_wcity_o = p_q;
  assign tbl_wcost_o = best_q;
  assign tbl_wnext_o = best_city_q;

  // Tour words
  assign out_if.valid     = out_valid_q;
  assign out_if.city      = hkts_pkg::CITY_W'(out_city_q);
  assign out_if.tour_cost = hkts_pkg::COST_OUT_W'(cost_q);
  assign out_if.last      = out_last_q;

  // Next state, addresses and datapath
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    p_d         = p_q;
    nx_d        = nx_q;
    cnt_d       = cnt_q;
    cost_d      = cost_q;
    s1_valid_d  = 1'b0;
    s1_full_d   = s1_full_q;
    s1_nx_d     = nx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_city_d = best_city_q;
    out_valid_d = out_valid_q;
    out_city_d  = out_city_q;
    out_last_d  = out_last_q;
    advance     = 1'b0;
    tbl_we_o    = 1'b0;

    dist_a_row_o = p_q;
    dist_a_col_o = nx_q;
    dist_b_row_o = nx_q;
    tbl_rmask_o  = next_mask[MAX_CITIES-1:1];
    tbl_rcity_o  = nx_q;

    // keep the cheapest candidate, lowest city on ties
    if (s1_valid_q && (!found_q || (cand < best_q))) begin
      found_d     = 1'b1;
      best_d      = cand;
      best_city_d = s1_nx_q;
    end

    case (state_q)
      hkts_pkg::ST_IDLE: begin
        if (in_acc && (in_if.mode == hkts_pkg::MODE_SOLVE)) begin
          p_d = '0;
          if (n_i == CNT_W'(1)) begin
            m_d     = MAX_CITIES'(1);
            state_d = hkts_pkg::ST_TOUR_RD;
          end else begin
            m_d     = full_mask - MAX_CITIES'(2);
            state_d = hkts_pkg::ST_PICK;
          end
        end
      end
      hkts_pkg::ST_PICK: begin
        if (m_q[p_q]) begin
          nx_d    = '0;
          found_d = 1'b0;
          state_d = hkts_pkg::ST_SCAN;
        end else begin
          advance = 1'b1;
        end
      end
      hkts_pkg::ST_SCAN: begin
        // issue one candidate per cycle
        s1_valid_d = !m_q[nx_q];
        s1_full_d  = (next_mask == full_mask);
        if (nx_last) begin
          state_d = hkts_pkg::ST_FLUSH;
        end else begin
          nx_d = nx_q + CIW'(1);
        end
      end
      hkts_pkg::ST_FLUSH: begin
        state_d = hkts_pkg::ST_STORE;
      end
      hkts_pkg::ST_STORE: begin
        tbl_we_o = 1'b1;
        advance  = 1'b1;
      end
      hkts_pkg::ST_TOUR_RD: begin
        tbl_rmask_o  = m_q[MAX_CITIES-1:1];
        tbl_rcity_o  = p_q;
        dist_b_row_o = '0;
        state_d      = hkts_pkg::ST_TOUR_CAP0;
      end
      hkts_pkg::ST_TOUR_CAP0: begin
        cost_d      = (n_i == CNT_W'(1)) ? COST_W'(dist_b_data_i) : tbl_rcost_i;
        out_valid_d = 1'b1;
        out_city_d  = '0;
        out_last_d  = 1'b0;
        cnt_d       = CNT_W'(1);
        state_d     = hkts_pkg::ST_TOUR_OUT;
      end
      hkts_pkg::ST_TOUR_OUT: begin
        tbl_rmask_o = m_q[MAX_CITIES-1:1];
        tbl_rcity_o = p_q;
        if (out_if.ready) begin
          if (out_last_q) begin
            out_valid_d = 1'b0;
            state_d     = hkts_pkg::ST_IDLE;
          end else if (cnt_q < n_i) begin
            out_valid_d = 1'b0;
            state_d     = hkts_pkg::ST_TOUR_CAP;
          end else begin
            // close the tour at home
            out_city_d = '0;
            out_last_d = 1'b1;
          end
        end
      end
      hkts_pkg::ST_TOUR_CAP: begin
        p_d         = tbl_rnext_i;
        m_d         = m_q | (MAX_CITIES'(1) << tbl_rnext_i);
        out_valid_d = 1'b1;
        out_city_d  = tbl_rnext_i;
        cnt_d       = cnt_q + CNT_W'(1);
        state_d     = hkts_pkg::ST_TOUR_OUT;
      end
      default: begin
        state_d = hkts_pkg::ST_IDLE;
      end
    endcase

    // Step to the next city, then to the next smaller mask
    if (advance) begin
      if (p_last) begin
        p_d = '0;
        if (m_q == MAX_CITIES'(1)) begin
          state_d = hkts_pkg::ST_TOUR_RD;
        end else begin
          m_d     = m_q - MAX_CITIES'(2);
          state_d = hkts_pkg::ST_PICK;
        end
      end else begin
        p_d     = p_q + CIW'(1);
        state_d = hkts_pkg::ST_PICK;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkts_pkg::ST_IDLE;
      s1_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m_q         <= m_d;
    p_q         <= p_d;
    nx_q        <= nx_d;
    cost_q      <= cost_d;
    s1_full_q   <= s1_full_d;
    s1_nx_q     <= s1_nx_d;
    best_q      <= best_d;
    best_city_q <= best_city_d;
    out_city_q  <= out_city_d;
  end

endmodule
`default_nettype wire

>>> hdl/held_karp_tour_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Held-Karp tour solver
// Exact closed-tour solver over a loaded weight matrix by subset dynamic
// programming in an on-chip table.
//
//   Channel   Dir  Word
//   in_if     in   mode, from_city, to_city, weight (load one edge or solve)
//   out_if    out  city, tour_cost, last (n+1 words per solve)
//   APB       in   city_count register at byte address 0
//
// A load word is taken while idle, and the next word may follow at once.
// A solve walks every odd mask below the full set, largest first; per city p
// in the mask it steps through pick, n reads, flush and write; else it skips.
// The cost is then read and captured; inner tour words follow a table read.
// No input word is taken until the last tour word of a solve is taken.
// Reset clears control state only; memories need no clearing pass.
// ----------------------------------------------------------------------------
module held_karp_tour_solver #(
  parameter int MAX_CITIES  = hkts_pkg::DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = hkts_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  hkts_in_if.sink                                in_if,
  hkts_out_if.source                             out_if,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hkts_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [hkts_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [hkts_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int CIW    = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int COST_W = WEIGHT_BITS + $clog2(MAX_CITIES);
  localparam int MW     = MAX_CITIES - 1;

  logic [hkts_pkg::COUNT_W-1:0]   city_count_q;
  logic [hkts_pkg::REG_IDX_W-1:0] reg_idx;
  logic [CNT_W-1:0]               n_active;

  logic                   dist_we;
  logic [CIW-1:0]         dist_wrow;
  logic [CIW-1:0]         dist_wcol;
  logic [WEIGHT_BITS-1:0] dist_wdata;
  logic [CIW-1:0]         dist_a_row;
  logic [CIW-1:0]         dist_a_col;
  logic [CIW-1:0]         dist_b_row;
  logic [WEIGHT_BITS-1:0] dist_a_data;
  logic [WEIGHT_BITS-1:0] dist_b_data;

  logic                   tbl_we;
  logic [MW-1:0]          tbl_wmask;
  logic [CIW-1:0]         tbl_wcity;
  logic [COST_W-1:0]      tbl_wcost;
  logic [CIW-1:0]         tbl_wnext;
  logic [MW-1:0]          tbl_rmask;
  logic [CIW-1:0]         tbl_rcity;
  logic [COST_W-1:0]      tbl_rcost;
  logic [CIW-1:0]         tbl_rnext;

  // Configuration register
  assign reg_idx = paddr[hkts_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= hkts_pkg::CITY_COUNT_RST;
    end else if (psel && penable && pwrite && (reg_idx == hkts_pkg::REG_CITY_COUNT)) begin
      city_count_q <= pwdata[hkts_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == hkts_pkg::REG_CITY_COUNT) begin
      prdata = hkts_pkg::APB_DATA_W'(city_count_q);
    end
  end

  // Clamp the city count to the built range
  always_comb begin
    if (city_count_q == '0) begin
      n_active = CNT_W'(1);
    end else if (int'(city_count_q) > MAX_CITIES) begin
      n_active = CNT_W'(MAX_CITIES);
    end else begin
      n_active = CNT_W'(city_count_q);
    end
  end

  hkts_ctrl #(
    .MAX_CITIES  (MAX_CITIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n_active),
    .in_if         (in_if),
    .out_if        (out_if),
    .dist_we_o     (dist_we),
    .dist_wrow_o   (dist_wrow),
    .dist_wcol_o   (dist_wcol),
    .dist_wdata_o  (dist_wdata),
    .dist_a_row_o  (dist_a_row),
    .dist_a_col_o  (dist_a_col),
    .dist_b_row_o  (dist_b_row),
    .dist_a_data_i (dist_a_data),
    .dist_b_data_i (dist_b_data),
    .tbl_we_o      (tbl_we),
    .tbl_wmask_o   (tbl_wmask),
    .tbl_wcity_o   (tbl_wcity),
    .tbl_wcost_o   (tbl_wcost),
    .tbl_wnext_o   (tbl_wnext),
    .tbl_rmask_o   (tbl_rmask),
    .tbl_rcity_o   (tbl_rcity),
    .tbl_rcost_i   (tbl_rcost),
    .tbl_rnext_i   (tbl_rnext)
  );

  hkts_dist_mem #(
    .MAX_CITIES  (MAX_CITIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dist_mem (
    .clk_i    (clk_i),
    .we_i     (dist_we),
    .wrow_i   (dist_wrow),
    .wcol_i   (dist_wcol),
    .wdata_i  (dist_wdata),
    .a_row_i  (dist_a_row),
    .a_col_i  (dist_a_col),
    .b_row_i  (dist_b_row),
    .a_data_o (dist_a_data),
    .b_data_o (dist_b_data)
  );

  hkts_table_mem #(
    .MAX_CITIES  (MAX_CITIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_table_mem (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .wmask_i (tbl_wmask),
    .wcity_i (tbl_wcity),
    .wcost_i (tbl_wcost),
    .wnext_i (tbl_wnext),
    .rmask_i (tbl_rmask),
    .rcity_i (tbl_rcity),
    .rcost_o (tbl_rcost),
    .rnext_o (tbl_rnext)
  );

endmodule
`default_nettype wire
